[sv/ffra_pkg.sv]
// Shared types and constants for the first-fit region allocator.
package ffra_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int ADDR_BITS   = 17;
    localparam int IDX_BITS    = $clog2(MAX_REGIONS);
    localparam int CNT_BITS    = $clog2(MAX_REGIONS + 1);
    localparam int OWNER_BITS  = 16;
    localparam logic [ADDR_BITS-1:0] MEM_LIMIT =
        ((1 << ADDR_BITS) - 1 < 65536) ? ADDR_BITS'((1 << ADDR_BITS) - 1)
                                       : ADDR_BITS'(65536);

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NOT_OWN  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  start_addr;
        logic [ADDR_BITS-1:0]  end_addr;
        logic                  free;
        logic [OWNER_BITS-1:0] owner;
    } region_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_UP_RD,
        S_SHIFT_UP_WR,
        S_SPLIT_WR,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_SHIFT_DN_RD,
        S_SHIFT_DN_WR,
        S_RESULT
    } state_t;

endpackage

[sv/first_fit_region_allocator_unit.sv]
// Top level of the first-fit region allocator: sequencer around the region table memory.
//
// The region table sits in one memory of MAX_REGIONS entries with one write port and
// a registered read port. Each request walks the table one entry at a time from the
// lowest address; an allocate that splits a region shifts the later entries up,
// and a free that merges shifts them down, one moved entry at a time. An allocate
// of zero units and an unused request type skip the walk and go straight to the
// result. After reset and after each total_memory write the block rebuilds the
// table before it accepts an item. The result is held in an output register; the
// next item is taken once that register is free.
module first_fit_region_allocator_unit
    import ffra_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] req_type, [17:2] owner_id, [34:18] request_size
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [18:2] region_start, [19] is_allocated, [36:20] used_units,
    // [68:37] alloc_count, [100:69] free_count
    output logic [103:0] m_tdata
);

    region_t mem [MAX_REGIONS];
    logic             we;
    logic [IDX_BITS-1:0] waddr, raddr;
    region_t          wdata, rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] total_reg, total_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [ADDR_BITS-1:0] used_reg, used_next;
    logic [31:0] allocs_reg, allocs_next, frees_reg, frees_next;
    logic [CNT_BITS-1:0]  i_reg, i_next, j_reg, j_next;
    logic [1:0]  req_reg, req_next;
    logic [OWNER_BITS-1:0] own_reg, own_next;
    logic [ADDR_BITS-1:0]  size_reg, size_next;
    region_t     cur_reg, cur_next;
    logic [1:0]  st_reg, st_next;
    logic [ADDR_BITS-1:0] rstart_reg, rstart_next;
    logic        held_reg, held_next, mval_reg, mval_next;

    logic [ADDR_BITS-1:0] len;
    logic [16:0] cfg_v;
    logic        size_zero;

    assign cfg_ready = (state_reg == S_IDLE) && !mval_reg;
    assign s_tready  = (state_reg == S_IDLE) && !mval_reg && !cfg_valid;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = {3'd0, frees_reg, allocs_reg, used_reg, held_reg, rstart_reg, st_reg};
    assign len = rdata_reg.end_addr - rdata_reg.start_addr + ADDR_BITS'(1);
    assign size_zero = (size_reg == '0);

    always_comb begin
        cfg_v = cfg_data;
        if (cfg_v == '0) cfg_v = 17'd1;
        if (ADDR_BITS'(cfg_v) > MEM_LIMIT || (ADDR_BITS < 17 && cfg_v > 17'(MEM_LIMIT)))
            cfg_v = 17'(MEM_LIMIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT;
            total_reg  <= ADDR_BITS'(16384);
            count_reg  <= CNT_BITS'(1);
            used_reg   <= '0;
            allocs_reg <= '0;
            frees_reg  <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
            allocs_reg <= allocs_next;
            frees_reg  <= frees_next;
            mval_reg   <= mval_next;
        end
        i_reg <= i_next;  j_reg <= j_next;
        req_reg <= req_next; own_reg <= own_next; size_reg <= size_next;
        cur_reg <= cur_next; st_reg <= st_next; rstart_reg <= rstart_next;
        held_reg <= held_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cfg_valid && cfg_ready) state_next = S_INIT;
                else if (s_tvalid && s_tready) begin
                    if (s_tdata[1:0] == REQ_ALLOC && s_tdata[34:18] == '0)
                        state_next = S_RESULT;
                    else if (s_tdata[1:0] inside {REQ_ALLOC, REQ_FREE, REQ_QUERY})
                        state_next = S_SCAN_RD;
                    else state_next = S_RESULT;
                end
            end
            S_INIT: state_next = S_IDLE;
            S_SCAN_RD: state_next = (i_reg >= count_reg) ? S_RESULT : S_SCAN_CHK;
            S_SCAN_CHK: begin
                state_next = S_SCAN_RD;
                if (req_reg == REQ_ALLOC) begin
                    if (rdata_reg.free && len >= size_reg) begin
                        if (len == size_reg) state_next = S_RESULT;
                        else if (count_reg >= CNT_BITS'(MAX_REGIONS)) state_next = S_RESULT;
                        else state_next = S_SHIFT_UP_RD;
                    end
                end else if (!rdata_reg.free && rdata_reg.owner == own_reg) begin
                    state_next = (req_reg == REQ_FREE) ? S_FREE_NEXT : S_RESULT;
                end
            end
            S_SHIFT_UP_RD: state_next = (j_reg > i_reg + 1'b1) ? S_SHIFT_UP_WR : S_SPLIT_WR;
            S_SHIFT_UP_WR: state_next = S_SHIFT_UP_RD;
            S_SPLIT_WR: state_next = S_RESULT;
            S_FREE_NEXT: state_next = S_FREE_PREV;
            S_FREE_PREV: state_next = S_SHIFT_DN_RD;
            S_SHIFT_DN_RD: state_next = (j_reg + CNT_BITS'(drops_reg) < count_reg) ?
                                        S_SHIFT_DN_WR : S_RESULT;
            S_SHIFT_DN_WR: state_next = S_SHIFT_DN_RD;
            S_RESULT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // The free path reads neighbors i+1 then i-1, merging into cur_reg; a merge
    // leaves a gap of drops entries at index j that S_SHIFT_DN closes in one pass.
    logic [1:0] drops_reg, drops_next;
    always_ff @(posedge aclk) begin
        drops_reg <= drops_next;
    end

    always_comb begin
        total_next = total_reg; count_next = count_reg; used_next = used_reg;
        allocs_next = allocs_reg; frees_next = frees_reg; mval_next = mval_reg;
        i_next = i_reg; j_next = j_reg; req_next = req_reg; own_next = own_reg;
        size_next = size_reg; cur_next = cur_reg; st_next = st_reg;
        rstart_next = rstart_reg; held_next = held_reg;
        drops_next = drops_reg;
        we = 1'b0; waddr = '0; wdata = cur_reg; raddr = i_reg[IDX_BITS-1:0];
        if (mval_reg && m_tready) mval_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (cfg_valid && cfg_ready) total_next = ADDR_BITS'(cfg_v);
                else if (s_tvalid && s_tready) begin
                    req_next = s_tdata[1:0];
                    own_next = s_tdata[17:2];
                    size_next = ADDR_BITS'(s_tdata[34:18]);
                    i_next = '0;
                    st_next = (s_tdata[1:0] == REQ_ALLOC) ? ST_NO_FIT : ST_DONE;
                    if (s_tdata[1:0] == REQ_FREE) st_next = ST_NOT_OWN;
                    rstart_next = '0; held_next = 1'b0;
                end
            end
            S_INIT: begin
                we = 1'b1; waddr = '0;
                wdata.start_addr = ADDR_BITS'(1); wdata.end_addr = total_reg;
                wdata.free = 1'b1; wdata.owner = '0;
                count_next = CNT_BITS'(1); used_next = '0;
            end
            S_SCAN_RD: raddr = i_reg[IDX_BITS-1:0];
            S_SCAN_CHK: begin
                i_next = i_reg + 1'b1;
                cur_next = rdata_reg;
                if (req_reg == REQ_ALLOC) begin
                    if (rdata_reg.free && len >= size_reg) begin
                        i_next = i_reg;
                        if (len != size_reg && count_reg >= CNT_BITS'(MAX_REGIONS))
                            st_next = ST_FULL;
                        else begin
                            st_next = ST_DONE;
                            rstart_next = rdata_reg.start_addr;
                            used_next = used_reg + size_reg;
                            allocs_next = allocs_reg + 32'd1;
                            j_next = count_reg;
                            if (len == size_reg) begin
                                we = 1'b1; waddr = i_reg[IDX_BITS-1:0];
                                wdata = rdata_reg; wdata.free = 1'b0; wdata.owner = own_reg;
                            end
                        end
                    end
                end else if (!rdata_reg.free && rdata_reg.owner == own_reg) begin
                    i_next = i_reg;
                    if (req_reg == REQ_QUERY) held_next = 1'b1;
                    else begin
                        st_next = ST_DONE;
                        used_next = used_reg - len;
                        frees_next = frees_reg + 32'd1;
                        cur_next.free = 1'b1; cur_next.owner = '0;
                        drops_next = '0;
                    end
                end
                if (state_next == S_FREE_NEXT) raddr = IDX_BITS'(i_reg + 1'b1);
            end
            S_SHIFT_UP_RD: raddr = IDX_BITS'(j_reg - 1'b1);
            S_SHIFT_UP_WR: begin
                we = 1'b1; waddr = j_reg[IDX_BITS-1:0]; wdata = rdata_reg;
                j_next = j_reg - 1'b1;
            end
            S_SPLIT_WR: begin
                // remainder written here into the slot above; front part is written in S_RESULT
                we = 1'b1; waddr = IDX_BITS'(i_reg + 1'b1);
                wdata.start_addr = cur_reg.start_addr + size_reg;
                wdata.end_addr = cur_reg.end_addr; wdata.free = 1'b1; wdata.owner = '0;
                cur_next.end_addr = cur_reg.start_addr + size_reg - ADDR_BITS'(1);
                cur_next.free = 1'b0; cur_next.owner = own_reg;
                count_next = count_reg + 1'b1;
            end
            S_FREE_NEXT: begin
                // rdata holds entry i+1
                raddr = IDX_BITS'(i_reg - 1'b1);
                if (i_reg + 1'b1 < count_reg && rdata_reg.free &&
                    cur_reg.end_addr + ADDR_BITS'(1) == rdata_reg.start_addr) begin
                    cur_next.end_addr = rdata_reg.end_addr;
                    drops_next = 2'd1;
                end
            end
            S_FREE_PREV: begin
                // rdata holds entry i-1; merged entry lands at i or i-1
                j_next = i_reg + 1'b1;
                if (i_reg > 0 && rdata_reg.free &&
                    rdata_reg.end_addr + ADDR_BITS'(1) == cur_reg.start_addr) begin
                    we = 1'b1; waddr = IDX_BITS'(i_reg - 1'b1);
                    wdata = rdata_reg; wdata.end_addr = cur_reg.end_addr;
                    j_next = i_reg;
                    drops_next = drops_reg + 2'd1;
                end else begin
                    we = 1'b1; waddr = i_reg[IDX_BITS-1:0]; wdata = cur_reg;
                end
                if (drops_reg == 2'd0 && !(i_reg > 0 && rdata_reg.free &&
                    rdata_reg.end_addr + ADDR_BITS'(1) == cur_reg.start_addr))
                    j_next = count_reg;
            end
            S_SHIFT_DN_RD: begin
                // move entry j+drops down to j
                raddr = IDX_BITS'(j_reg + CNT_BITS'(drops_reg));
                if (!(j_reg + CNT_BITS'(drops_reg) < count_reg))
                    count_next = count_reg - CNT_BITS'(drops_reg);
            end
            S_SHIFT_DN_WR: begin
                we = 1'b1; waddr = j_reg[IDX_BITS-1:0]; wdata = rdata_reg;
                j_next = j_reg + 1'b1;
                if (j_reg + CNT_BITS'(drops_reg) + 1'b1 >= count_reg) begin
                    j_next = count_reg;
                end
            end
            S_RESULT: begin
                if (req_reg == REQ_ALLOC && st_reg == ST_DONE && size_reg != '0 &&
                    cur_reg.free) begin
                    we = 1'b1; waddr = i_reg[IDX_BITS-1:0];
                    wdata = cur_reg; wdata.free = 1'b0; wdata.owner = own_reg;
                end else if (req_reg == REQ_ALLOC && st_reg == ST_DONE && !cur_reg.free) begin
                    we = 1'b1; waddr = i_reg[IDX_BITS-1:0]; wdata = cur_reg;
                end
                if (req_reg == REQ_ALLOC && size_zero) st_next = ST_NO_FIT;
                mval_next = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[sv/ffra_checker.sv]
// Port-level checks for the first-fit region allocator, bound to the top level.
module ffra_checker
    import ffra_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [103:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_noaccept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("item taken while result pending");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_DONE |-> m_tdata[18:2] == '0)
        else $error("start given on failure");
    a_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tdata[1:0] == ST_DONE)
        else $error("query bad status");
endmodule

bind first_fit_region_allocator_unit ffra_checker u_ffra_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/first_fit_region_allocator_unit_tb.sv]
// Self-checking testbench for the first-fit region allocator unit.
`timescale 1ns / 100ps

module first_fit_region_allocator_unit_tb;
    import ffra_pkg::*;

    typedef struct packed {
        logic [16:0] size;
        logic [15:0] owner;
        logic [1:0]  req;
    } req_item_t;

    typedef struct packed {
        logic [31:0] frees;
        logic [31:0] allocs;
        logic [16:0] used;
        logic        held;
        logic [16:0] start;
        logic [1:0]  status;
    } alloc_result_t;

    // job queue entry: a request, a total_memory write or a drain marker
    typedef struct packed {
        logic        is_cfg;
        logic        drain;
        logic [16:0] cfg_val;
        req_item_t   item;
    } job_t;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [16:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    first_fit_region_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [16:0] tbl_start [MAX_REGIONS];
    logic [16:0] tbl_end   [MAX_REGIONS];
    logic        tbl_free  [MAX_REGIONS];
    logic [15:0] tbl_owner [MAX_REGIONS];
    int          tbl_cnt;
    logic [16:0] mem_size;
    logic [16:0] used_sum;
    logic [31:0] n_allocs;
    logic [31:0] n_frees;

    job_t          jobs [$];
    alloc_result_t expected_results [$];
    int            errors;
    int            owner_pool;
    bit            stim_done;

    task automatic report(input string what);
        $display("ERROR %0t: %s", $time, what);
        errors++;
    endtask

    function automatic void clear_table();
        tbl_start[0] = 17'd1;
        tbl_end[0]   = mem_size;
        tbl_free[0]  = 1'b1;
        tbl_owner[0] = '0;
        tbl_cnt      = 1;
        used_sum     = '0;
    endfunction

    function automatic void set_mem_size(input logic [16:0] v);
        logic [16:0] t;
        t = v;
        if (t == '0) t = 17'd1;
        if (t > MEM_LIMIT) t = MEM_LIMIT;
        mem_size = t;
        clear_table();
    endfunction

    function automatic void remove_region(input int k);
        for (int j = k; j + 1 < tbl_cnt; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_end[j]   = tbl_end[j+1];
            tbl_free[j]  = tbl_free[j+1];
            tbl_owner[j] = tbl_owner[j+1];
        end
        tbl_cnt--;
    endfunction

    function automatic alloc_result_t predict_request(input req_item_t it);
        alloc_result_t r;
        logic [17:0] len;
        int i;
        r = '0;
        case (it.req)
            REQ_ALLOC: begin
                r.status = ST_NO_FIT;
                if (it.size != 0) begin
                    for (i = 0; i < tbl_cnt; i++) begin
                        len = 18'(tbl_end[i]) - 18'(tbl_start[i]) + 18'd1;
                        if (!tbl_free[i] || len < 18'(it.size)) continue;
                        if (len > 18'(it.size)) begin
                            if (tbl_cnt >= MAX_REGIONS) begin
                                r.status = ST_FULL;
                                break;
                            end
                            for (int j = tbl_cnt; j > i + 1; j--) begin
                                tbl_start[j] = tbl_start[j-1];
                                tbl_end[j]   = tbl_end[j-1];
                                tbl_free[j]  = tbl_free[j-1];
                                tbl_owner[j] = tbl_owner[j-1];
                            end
                            tbl_start[i+1] = tbl_start[i] + it.size;
                            tbl_end[i+1]   = tbl_end[i];
                            tbl_free[i+1]  = 1'b1;
                            tbl_owner[i+1] = '0;
                            tbl_cnt++;
                            tbl_end[i] = tbl_start[i] + it.size - 17'd1;
                        end
                        tbl_free[i]  = 1'b0;
                        tbl_owner[i] = it.owner;
                        used_sum     = used_sum + it.size;
                        n_allocs++;
                        r.start  = tbl_start[i];
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            REQ_FREE: begin
                for (i = 0; i < tbl_cnt; i++)
                    if (!tbl_free[i] && tbl_owner[i] == it.owner) break;
                if (i >= tbl_cnt) begin
                    r.status = ST_NOT_OWN;
                end else begin
                    used_sum = used_sum - (tbl_end[i] - tbl_start[i] + 17'd1);
                    tbl_free[i]  = 1'b1;
                    tbl_owner[i] = '0;
                    if (i + 1 < tbl_cnt && tbl_free[i+1] &&
                        18'(tbl_end[i]) + 1 == 18'(tbl_start[i+1])) begin
                        tbl_end[i] = tbl_end[i+1];
                        remove_region(i + 1);
                    end
                    if (i > 0 && tbl_free[i-1] &&
                        18'(tbl_end[i-1]) + 1 == 18'(tbl_start[i])) begin
                        tbl_end[i-1] = tbl_end[i];
                        remove_region(i);
                    end
                    n_frees++;
                    r.status = ST_DONE;
                end
            end
            REQ_QUERY: begin
                for (i = 0; i < tbl_cnt; i++)
                    if (!tbl_free[i] && tbl_owner[i] == it.owner) r.held = 1'b1;
            end
            default: ;
        endcase
        r.used   = used_sum;
        r.allocs = n_allocs;
        r.frees  = n_frees;
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // sender
    int   s_gap;
    int   settle;
    job_t cur;
    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_gap     = 0;
        settle    = 0;
        errors    = 0;
        stim_done = 1'b0;
        mem_size  = 17'd16384;
        n_allocs  = '0;
        n_frees   = '0;
        clear_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cfg_valid <= 1'b0;
                set_mem_size(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                expected_results = {expected_results,
                                    predict_request(req_item_t'(s_tdata[34:0]))};
            end
            if ((cfg_valid && !cfg_ready) || (s_tvalid && !s_tready)) begin
                // hold
            end else if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap--;
            end else if (jobs.size() == 0) begin
                s_tvalid <= 1'b0;
                if (!(s_tvalid && s_tready) && !cfg_valid) stim_done <= 1'b1;
            end else begin
                cur = jobs[0];
                if (cur.is_cfg || cur.drain) begin
                    s_tvalid <= 1'b0;
                    // wait for everything out, then let the block settle
                    if (expected_results.size() == 0 && !(s_tvalid && s_tready)) begin
                        if (settle < 300) settle++;
                        else begin
                            settle = 0;
                            void'(jobs.pop_front());
                            if (cur.is_cfg) begin
                                cfg_valid <= 1'b1;
                                cfg_data  <= cur.cfg_val;
                            end
                        end
                    end
                end else begin
                    void'(jobs.pop_front());
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, cur.item};
                    s_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                    if ($urandom_range(0, 9) < 4) s_gap = 0;
                end
            end
        end
    end

    // receiver
    int m_gap;
    initial begin
        m_tready = 1'b0;
        m_gap    = 0;
    end

    always @(posedge aclk) begin
        alloc_result_t got, exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = alloc_result_t'(m_tdata[100:0]);
                if (expected_results.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.status !== exp_r.status)
                        report($sformatf("status %0d exp %0d", got.status, exp_r.status));
                    if (got.start !== exp_r.start)
                        report($sformatf("region_start %0d exp %0d", got.start, exp_r.start));
                    if (got.held !== exp_r.held)
                        report($sformatf("is_allocated %0d exp %0d", got.held, exp_r.held));
                    if (got.used !== exp_r.used)
                        report($sformatf("used_units %0d exp %0d", got.used, exp_r.used));
                    if (got.allocs !== exp_r.allocs)
                        report($sformatf("alloc_count %0d exp %0d", got.allocs, exp_r.allocs));
                    if (got.frees !== exp_r.frees)
                        report($sformatf("free_count %0d exp %0d", got.frees, exp_r.frees));
                end
                m_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            end
            if (m_gap > 0) begin
                m_tready <= 1'b0;
                m_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void add_req(input logic [1:0] rq, input logic [15:0] ow,
                                    input logic [16:0] sz);
        job_t j;
        j = '0;
        j.item.req   = rq;
        j.item.owner = ow;
        j.item.size  = sz;
        jobs = {jobs, j};
    endfunction

    function automatic void add_cfg(input logic [16:0] v);
        job_t j;
        j = '0;
        j.is_cfg  = 1'b1;
        j.cfg_val = v;
        jobs = {jobs, j};
    endfunction

    function automatic void add_drain();
        job_t j;
        j = '0;
        j.drain = 1'b1;
        jobs = {jobs, j};
    endfunction

    function automatic logic [16:0] rand_size(input logic [16:0] cap);
        case ($urandom_range(0, 9))
            0:       return 17'($urandom_range(0, 131071));
            1, 2:    return 17'($urandom_range(1, 4));
            default: return 17'($urandom_range(1, cap));
        endcase
    endfunction

    // random phase with a given address space size
    function automatic void add_phase(input logic [16:0] msize, input int n);
        logic [15:0] ow;
        int k;
        add_cfg(msize);
        owner_pool = $urandom_range(2, 40);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) ow = 16'($urandom);
            else ow = 16'($urandom_range(0, owner_pool));
            case ($urandom_range(0, 19))
                0:                add_req(REQ_UNUSED, ow, 17'($urandom));
                1, 2, 3, 4:       add_req(REQ_QUERY, ow, 17'($urandom));
                5, 6, 7, 8, 9, 10: add_req(REQ_FREE, ow, 17'($urandom));
                default: add_req(REQ_ALLOC, ow,
                                 rand_size((msize > 40) ? msize / 20 : msize));
            endcase
        end
    endfunction

    // directed part plus random phases
    initial begin
        add_req(REQ_ALLOC, 16'h0000, 17'd0);
        add_req(REQ_ALLOC, 16'hFFFF, 17'd1);
        add_req(REQ_ALLOC, 16'h0000, 17'd100);
        add_req(REQ_ALLOC, 16'hFFFF, 17'd50);
        add_req(REQ_QUERY, 16'hFFFF, 17'h1FFFF);
        add_req(REQ_QUERY, 16'h1234, 17'd0);
        add_req(REQ_FREE,  16'h1234, 17'd0);
        add_req(REQ_FREE,  16'hFFFF, 17'd0);
        add_req(REQ_FREE,  16'h0000, 17'd0);
        add_req(REQ_FREE,  16'hFFFF, 17'd0);
        add_req(REQ_UNUSED, 16'hAAAA, 17'h15555);
        add_req(REQ_ALLOC, 16'h5555, 17'h1FFFF);
        add_req(REQ_ALLOC, 16'h5555, 17'd16384);
        add_req(REQ_QUERY, 16'h5555, 17'd0);
        add_req(REQ_FREE,  16'h5555, 17'd0);
        add_drain();
        add_cfg(17'd0);
        add_req(REQ_ALLOC, 16'd7, 17'd2);
        add_req(REQ_ALLOC, 16'd7, 17'd1);
        add_cfg(17'h1FFFF);
        add_req(REQ_ALLOC, 16'd3, 17'd65536);
        add_req(REQ_FREE,  16'd3, 17'd0);
        // fill the table with size-1 splits to hit the table-full case
        add_cfg(17'd100);
        for (int k = 0; k < 34; k++) add_req(REQ_ALLOC, 16'(k), 17'd1);
        add_phase(17'd65536, 400);
        add_phase(17'd40, 400);
        add_phase(17'd1, 60);
        add_phase(17'($urandom_range(2, 65535)), 400);
        add_phase(17'd16384, 500);
    end

    // end of run
    initial begin
        wait (aresetn === 1'b1);
        wait (stim_done && expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
sv/ffra_pkg.sv
sv/first_fit_region_allocator_unit.sv
sv/ffra_checker.sv
tb/first_fit_region_allocator_unit_tb.sv
